[src/mbe_pkg.sv]
// Shared types, constants and widths for the escape-time iteration block.
package mbe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int C_W       = 32;
    localparam int CNT_W     = 16;
    localparam int Z_W       = ((FRAC_BITS + 3 > C_W) ? FRAC_BITS + 3 : C_W) + 1;
    localparam int P_W       = 2 * Z_W;
    localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(1000);
    localparam logic [P_W:0]     ESC_THR     = (P_W + 1)'(1) << ESC_SHIFT;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_MUL,
        ST_TEST,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
        logic mul;
        logic incr;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic limit_at_start;
        logic escape;
        logic at_limit;
        logic out_free;
    } stat_t;

endpackage

[src/mbe_ctrl.sv]
// Sequencer for one point: start, z update, squaring, escape test, result load.
module mbe_ctrl import mbe_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_tvalid,
    output logic   s_tready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = stat.limit_at_start ? ST_EMIT : ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (stat.escape) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.incr   = 1'b1;
                    state_next = stat.at_limit ? ST_EMIT : ST_STEP;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/mbe_datapath.sv]
// Datapath: limit register, z registers, squaring multipliers, escape compare, result register.
module mbe_datapath import mbe_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    input  logic [CNT_W-1:0]        cfg_data,
    input  logic signed [C_W-1:0]   c_real,
    input  logic signed [C_W-1:0]   c_imag,
    input  cmd_t                    cmd,
    output stat_t                   stat,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic [31:0]             m_tdata,    // [15:0] iteration_count, [23:16] red,
                                                // [30:24] green, [31] zero
    output logic                    m_tuser     // [0] in_set
);

    logic [CNT_W-1:0]      limit_reg;
    logic signed [Z_W-1:0] cr_reg;
    logic signed [Z_W-1:0] ci_reg;
    logic signed [Z_W-1:0] x_reg;
    logic signed [Z_W-1:0] y_reg;
    logic signed [P_W-1:0] xx_reg;
    logic signed [P_W-1:0] yy_reg;
    logic signed [P_W-1:0] xy_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  m_tvalid_reg;
    logic [CNT_W-1:0]      out_count_reg;
    logic                  out_in_set_reg;
    logic [7:0]            out_red_reg;
    logic [6:0]            out_green_reg;

    logic signed [P_W:0]   diff_w;
    logic signed [P_W:0]   dbl_w;
    logic signed [P_W:0]   diff_sh;
    logic signed [P_W:0]   dbl_sh;
    logic signed [Z_W-1:0] x_next;
    logic signed [Z_W-1:0] y_next;
    logic [P_W:0]          mag;
    logic [CNT_W:0]        count_inc;
    logic                  in_set;

    assign diff_w  = {xx_reg[P_W-1], xx_reg} - {yy_reg[P_W-1], yy_reg};
    assign dbl_w   = {xy_reg, 1'b0};
    assign diff_sh = diff_w >>> FRAC_BITS;
    assign dbl_sh  = dbl_w >>> FRAC_BITS;
    assign x_next  = diff_sh[Z_W-1:0] + cr_reg;
    assign y_next  = dbl_sh[Z_W-1:0] + ci_reg;

    assign mag       = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign count_inc = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign in_set    = (count_reg == limit_reg);

    assign stat.limit_at_start = (limit_reg <= CNT_W'(1));
    assign stat.escape         = (mag > ESC_THR);
    assign stat.at_limit       = (count_inc >= {1'b0, limit_reg});
    assign stat.out_free       = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cr_reg    <= {{(Z_W - C_W){c_real[C_W-1]}}, c_real};
            ci_reg    <= {{(Z_W - C_W){c_imag[C_W-1]}}, c_imag};
            xx_reg    <= '0;
            yy_reg    <= '0;
            xy_reg    <= '0;
            count_reg <= CNT_W'(1);
        end else begin
            if (cmd.step) begin
                x_reg <= x_next;
                y_reg <= y_next;
            end
            if (cmd.mul) begin
                xx_reg <= x_reg * x_reg;
                yy_reg <= y_reg * y_reg;
                xy_reg <= x_reg * y_reg;
            end
            if (cmd.incr) begin
                count_reg <= count_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_count_reg  <= count_reg;
            out_in_set_reg <= in_set;
            out_red_reg    <= in_set ? 8'd0 : count_reg[7:0];
            out_green_reg  <= in_set ? 7'd0 : count_reg[7:1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_green_reg, out_red_reg, out_count_reg};
    assign m_tuser  = out_in_set_reg;

endmodule

[src/mandelbrot_escape_time.sv]
// Top level of the escape-time iteration block: controller, datapath and port wiring.
//
//  channel  | ports                          | payload
//  ---------+--------------------------------+------------------------------------------
//  input    | s_tvalid s_tready s_tdata      | c_real, c_imag (signed Q4.28)
//  result   | m_tvalid m_tready m_tdata      | iteration_count, red, green; in_set in
//           | m_tuser                        | m_tuser
//  config   | cfg_valid cfg_ready cfg_data   | iter_limit
//
//  One iteration steps through z update, squaring multipliers and escape compare. A point is
//  accepted, iterated until z escapes or the count reaches the limit, and its result loaded;
//  for a limit of 0 or 1 the point goes straight from accept to result load.
//  Reset (aresetn low, synchronous) sets iter_limit to 1000 and empties the result stage.
//  A new point is taken while the previous result still waits on m_tready; a point whose
//  result is done holds in the controller until the result register frees.
module mandelbrot_escape_time import mbe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] c_real, [63:32] c_imag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] iteration_count, [23:16] red, [30:24] green,
                                    // [31] zero
    output logic        m_tuser,    // [0] in_set
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data    // [15:0] iter_limit
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    mbe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mbe_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .c_real    (s_tdata[31:0]),
        .c_imag    (s_tdata[63:32]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.start, cmd.step, cmd.mul, cmd.incr, cmd.emit}))
        else $error("controller issued more than one command");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("result load did not raise m_tvalid");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[30:16] == 15'd0))
        else $error("in-set point not colored black");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[30:24] == m_tdata[23:17]))
        else $error("green is not red halved");
`endif

endmodule

[test/tb_mandelbrot_escape_time.sv]
// Testbench for mandelbrot_escape_time: stream stimulus, escape-time prediction, result scoreboard.
module tb_mandelbrot_escape_time;
    import mbe_pkg::*;

    typedef struct packed {
        logic [15:0] count;
        logic        in_set;
        logic [7:0]  red;
        logic [6:0]  green;
    } pixel_t;

    class escape_scoreboard;
        pixel_t      pixels_due[$];
        logic [15:0] limit;
        int          errors;

        function new();
            limit  = LIMIT_RESET;
            errors = 0;
        endfunction

        // exact fixed-point iteration, z kept in 64 bits, products in 128
        function pixel_t escape_pixel(logic signed [31:0] cr, logic signed [31:0] ci);
            logic signed [63:0]  x, y, nx, ny, crw, ciw;
            logic signed [127:0] xw, yw, nxw, nyw, t;
            logic [127:0]        mag;
            logic [127:0]        esc_level;
            logic [16:0]         count;
            logic                escaped;
            pixel_t              p;
            esc_level = 128'd1 << (2 * FRAC_BITS + 2);
            crw = cr;
            ciw = ci;
            x = '0;
            y = '0;
            count = 17'd1;
            escaped = 1'b0;
            while (count < {1'b0, limit} && !escaped) begin
                xw = x;
                yw = y;
                t  = (xw * xw - yw * yw) >>> FRAC_BITS;
                nx = t[63:0] + crw;
                t  = ((xw * yw) <<< 1) >>> FRAC_BITS;
                ny = t[63:0] + ciw;
                nxw = nx;
                nyw = ny;
                mag = nxw * nxw + nyw * nyw;
                x = nx;
                y = ny;
                if (mag > esc_level) begin
                    escaped = 1'b1;
                end else begin
                    count++;
                end
            end
            p.count  = count[15:0];
            p.in_set = (count == {1'b0, limit});
            p.red    = p.in_set ? 8'd0 : count[7:0];
            p.green  = p.in_set ? 7'd0 : count[7:1];
            return p;
        endfunction

        function void note_point(logic signed [31:0] cr, logic signed [31:0] ci);
            pixels_due.push_back(escape_pixel(cr, ci));
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        function void check_result(logic [31:0] data, logic user);
            pixel_t exp_px;
            if (pixels_due.size() == 0) begin
                $error("result transaction with no point pending: data %h user %b", data, user);
                errors++;
                return;
            end
            exp_px = pixels_due.pop_front();
            if (data[15:0] !== exp_px.count) begin
                $error("iteration_count: expected %0d, got %0d", exp_px.count, data[15:0]);
                errors++;
            end
            if (user !== exp_px.in_set) begin
                $error("in_set: expected %0d, got %0d", exp_px.in_set, user);
                errors++;
            end
            if (data[23:16] !== exp_px.red) begin
                $error("red: expected %0d, got %0d", exp_px.red, data[23:16]);
                errors++;
            end
            if (data[30:24] !== exp_px.green) begin
                $error("green: expected %0d, got %0d", exp_px.green, data[30:24]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    escape_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    mandelbrot_escape_time uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
    endtask

    task automatic send_point(input logic signed [31:0] cr, input logic signed [31:0] ci);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ci, cr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_point(cr, ci);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.limit = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly points around the set, the rest anywhere in the Q4.28 range
    task automatic send_random_point();
        logic signed [31:0] cr, ci;
        if ($urandom_range(99) < 75) begin
            cr = -32'sd536870912 + $signed({1'b0, 31'($urandom_range(0, 671088640))});
            ci = $signed({1'b0, 31'($urandom_range(0, 335544320))});
            if ($urandom_range(1)) ci = -ci;
        end else begin
            cr = $urandom;
            ci = $urandom;
        end
        send_point(cr, ci);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limit of 1000
        set_idling(0);
        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'shE000_0000, 32'sh0000_0000);
        send_point(32'sh2000_0000, 32'sh0000_0000);
        send_point(32'sh2000_0001, 32'sh0000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(32'sh0400_0000, 32'sh0000_0000);
        send_point(32'shF400_0000, 32'sh0199_999A);
        send_point(32'sh0000_0000, 32'sh1000_0000);
        send_point(32'sh0000_0000, 32'shF000_0000);
        send_point(32'shF000_0000, 32'sh0000_0000);
        send_point(32'sh04CC_CCCD, 32'sh0800_0000);
        send_point(-32'sd200064965, 32'sd30252676);
        send_point(32'sh0000_0001, 32'shFFFF_FFFF);
        drain();

        // limit of zero
        write_limit(16'd0);
        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        drain();

        // limit of one
        write_limit(16'd1);
        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        drain();

        write_limit(16'd2);
        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'sh2000_0000, 32'sh0000_0000);
        send_point(32'sh2000_0001, 32'sh0000_0001);
        drain();

        // widest limit: three points, the origin among them, which never escapes
        write_limit(16'hFFFF);
        send_point(32'sh04CC_CCCD, 32'sh0800_0000);
        send_point(-32'sd200064965, 32'sd30252676);
        send_point(32'sh0000_0000, 32'sh0000_0000);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_limit(16'd256);
                1: write_limit(16'd255);
                7: write_limit(16'd1000);
                default: write_limit(16'($urandom_range(3, 400)));
            endcase
            set_idling(phase % 4);
            for (int i = 0; i < 56; i++) begin
                send_random_point();
            end
            drain();
        end

        set_idling(0);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
src/mbe_pkg.sv
src/mbe_ctrl.sv
src/mbe_datapath.sv
src/mandelbrot_escape_time.sv
test/tb_mandelbrot_escape_time.sv
